[rtl/qpht_pkg.sv]
package qpht_pkg;

  localparam int unsigned MaxSlots = 64;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned KeyW     = 31;
  localparam int unsigned KeyBitW  = $clog2(KeyW);
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned InDataW  = ((KeyW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((SlotW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_LIMIT = 3'd4
  } status_e;

  localparam logic [CfgIdxW-1:0] RegCapacity  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLoadLimit = 2'd1;

  localparam logic [CfgDataW-1:0] CapacityReset  = 7'd7;
  localparam logic [CfgDataW-1:0] LoadLimitReset = 7'd6;

endpackage

[rtl/quadratic_probe_hash_table.sv]
// Open-addressing key set with quadratic probing over up to 64 slots.
// Commands arrive on the slave stream: tuser carries the command (insert,
// search or remove) and tdata the 31-bit key. One result per command leaves
// on the master stream: tuser carries the status and tdata the slot index.
// Two registers, capacity and load limit, are written through the
// configuration channel, which is always ready and must only be used while
// the block is idle.
// After a transfer in, the key is reduced modulo the capacity, one quotient bit per cycle,
// on the shared add-and-reduce unit. Each probe then passes a read state and a check
// state, because the read port of the key store is registered. A search or remove
// probes at most capacity slots; an insert that finds no match and is under the load
// limit then makes a free-slot pass from the home slot, taking the first slot that is
// not occupied. One command is held at a time; the input is ready again once the
// result sits in the output register, so a stalled receiver only blocks the command
// after next.
// Reset clears the occupied and tombstone bits and the entry count at once
// and restores capacity 7 and load limit 6; no clearing pass is needed.
module quadratic_probe_hash_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [qpht_pkg::InDataW-1:0]      s_axis_tdata,  // key
  input  logic [qpht_pkg::CmdW-1:0]         s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [qpht_pkg::OutDataW-1:0]     m_axis_tdata,  // slot_index
  output logic [qpht_pkg::StatusW-1:0]      m_axis_tuser,  // status
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qpht_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [qpht_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MOD    = 6'b000010,
    S_READ   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_INSERT = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e                              state_q;
  qpht_pkg::cmd_e                      cmd_q;
  logic [qpht_pkg::KeyW-1:0]           key_q;
  logic [qpht_pkg::CountW-1:0]         cap_reg_q, limit_q, cap_q, count_q, probe_q;
  logic [qpht_pkg::KeyBitW-1:0]        bit_q;
  logic [qpht_pkg::SlotW-1:0]          rem_q, home_q, slot_q, dlt_q;
  logic [qpht_pkg::MaxSlots-1:0]       occ_q, tomb_q;
  qpht_pkg::status_e                   res_status_q, m_status_q;
  logic [qpht_pkg::SlotW-1:0]          res_slot_q, m_slot_q;
  logic                                m_valid_q;

  logic [qpht_pkg::KeyW-1:0]           mem_q [qpht_pkg::MaxSlots];
  logic [qpht_pkg::KeyW-1:0]           rdata_q;
  logic                                mem_we;

  logic [qpht_pkg::CountW-1:0]         cap_eff, red_in;
  logic [qpht_pkg::SlotW-1:0]          red_out, dlt_next, dlt_init;
  logic [qpht_pkg::CountW:0]           dlt_sum;
  logic                                last_probe, hit, empty, out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = qpht_pkg::OutDataW'(m_slot_q);
  assign m_axis_tuser  = m_status_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    if (cap_reg_q == '0) begin
      cap_eff = qpht_pkg::CountW'(1);
    end else if (cap_reg_q > qpht_pkg::CountW'(qpht_pkg::MaxSlots)) begin
      cap_eff = qpht_pkg::CountW'(qpht_pkg::MaxSlots);
    end else begin
      cap_eff = cap_reg_q;
    end
  end

  // Shared unit: one add or shift, then one conditional subtract of the capacity.
  always_comb begin
    if (state_q == S_MOD) begin
      red_in = {rem_q, key_q[bit_q]};
    end else begin
      red_in = {1'b0, slot_q} + {1'b0, dlt_q};
    end
    if (red_in >= cap_q) begin
      red_out = qpht_pkg::SlotW'(red_in - cap_q);
    end else begin
      red_out = red_in[qpht_pkg::SlotW-1:0];
    end
  end

  // The probe offset steps by 2i+1, kept reduced modulo the capacity.
  always_comb begin
    dlt_sum = {2'b00, dlt_q} + (qpht_pkg::CountW+1)'(2);
    if (dlt_sum >= {cap_q, 1'b0}) begin
      dlt_next = qpht_pkg::SlotW'(dlt_sum - {cap_q, 1'b0});
    end else if (dlt_sum >= {1'b0, cap_q}) begin
      dlt_next = qpht_pkg::SlotW'(dlt_sum - {1'b0, cap_q});
    end else begin
      dlt_next = dlt_sum[qpht_pkg::SlotW-1:0];
    end
  end

  assign dlt_init   = (cap_q == qpht_pkg::CountW'(1)) ? '0 : qpht_pkg::SlotW'(1);
  assign last_probe = (probe_q == cap_q - qpht_pkg::CountW'(1));
  assign hit        = occ_q[slot_q] && (rdata_q == key_q);
  assign empty      = !occ_q[slot_q] && !tomb_q[slot_q];
  assign mem_we     = (state_q == S_INSERT) && !occ_q[slot_q];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= key_q;
    end
    rdata_q <= mem_q[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_reg_q    <= qpht_pkg::CapacityReset;
      limit_q      <= qpht_pkg::LoadLimitReset;
      count_q      <= '0;
      occ_q        <= '0;
      tomb_q       <= '0;
      m_valid_q    <= 1'b0;
      cmd_q        <= qpht_pkg::CMD_SEARCH;
      key_q        <= '0;
      cap_q        <= qpht_pkg::CountW'(1);
      probe_q      <= '0;
      bit_q        <= '0;
      rem_q        <= '0;
      home_q       <= '0;
      slot_q       <= '0;
      dlt_q        <= '0;
      res_status_q <= qpht_pkg::ST_MISS;
      res_slot_q   <= '0;
      m_status_q   <= qpht_pkg::ST_MISS;
      m_slot_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          qpht_pkg::RegCapacity:  cap_reg_q <= cfg_data_i;
          qpht_pkg::RegLoadLimit: limit_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == S_RESP) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= qpht_pkg::cmd_e'(s_axis_tuser);
            key_q   <= s_axis_tdata[qpht_pkg::KeyW-1:0];
            cap_q   <= cap_eff;
            rem_q   <= '0;
            bit_q   <= qpht_pkg::KeyBitW'(qpht_pkg::KeyW - 1);
            if (qpht_pkg::cmd_e'(s_axis_tuser) == qpht_pkg::CMD_UNUSED) begin
              res_status_q <= qpht_pkg::ST_MISS;
              res_slot_q   <= '0;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem_q <= red_out;
          if (bit_q == '0) begin
            home_q  <= red_out;
            slot_q  <= red_out;
            dlt_q   <= dlt_init;
            probe_q <= '0;
            state_q <= S_READ;
          end else begin
            bit_q <= bit_q - qpht_pkg::KeyBitW'(1);
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            state_q <= S_RESP;
            case (cmd_q)
              qpht_pkg::CMD_INSERT: begin
                res_status_q <= qpht_pkg::ST_DUP;
                res_slot_q   <= '0;
              end
              qpht_pkg::CMD_REMOVE: begin
                occ_q[slot_q]  <= 1'b0;
                tomb_q[slot_q] <= 1'b1;
                if (count_q != '0) begin
                  count_q <= count_q - qpht_pkg::CountW'(1);
                end
                res_status_q <= qpht_pkg::ST_OK;
                res_slot_q   <= slot_q;
              end
              default: begin
                res_status_q <= qpht_pkg::ST_OK;
                res_slot_q   <= slot_q;
              end
            endcase
          end else if (empty || last_probe) begin
            res_slot_q <= '0;
            if (cmd_q != qpht_pkg::CMD_INSERT) begin
              res_status_q <= qpht_pkg::ST_MISS;
              state_q      <= S_RESP;
            end else if (count_q >= limit_q) begin
              res_status_q <= qpht_pkg::ST_LIMIT;
              state_q      <= S_RESP;
            end else begin
              slot_q  <= home_q;
              dlt_q   <= dlt_init;
              probe_q <= '0;
              state_q <= S_INSERT;
            end
          end else begin
            slot_q  <= red_out;
            dlt_q   <= dlt_next;
            probe_q <= probe_q + qpht_pkg::CountW'(1);
            state_q <= S_READ;
          end
        end
        S_INSERT: begin
          if (!occ_q[slot_q]) begin
            occ_q[slot_q]  <= 1'b1;
            tomb_q[slot_q] <= 1'b0;
            count_q        <= count_q + qpht_pkg::CountW'(1);
            res_status_q   <= qpht_pkg::ST_OK;
            res_slot_q     <= slot_q;
            state_q        <= S_RESP;
          end else if (last_probe) begin
            res_status_q <= qpht_pkg::ST_FULL;
            res_slot_q   <= '0;
            state_q      <= S_RESP;
          end else begin
            slot_q  <= red_out;
            dlt_q   <= dlt_next;
            probe_q <= probe_q + qpht_pkg::CountW'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_status_q <= res_status_q;
            m_slot_q   <= res_slot_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/qpht_checker.sv]
module qpht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [qpht_pkg::OutDataW-1:0] m_axis_tdata,  // slot_index
  input logic [qpht_pkg::StatusW-1:0]  m_axis_tuser   // status
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == qpht_pkg::ST_OK) || (m_axis_tuser == qpht_pkg::ST_DUP) ||
      (m_axis_tuser == qpht_pkg::ST_MISS) || (m_axis_tuser == qpht_pkg::ST_FULL) ||
      (m_axis_tuser == qpht_pkg::ST_LIMIT))
    else $error("undefined status code");

  // Any status other than success carries slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != qpht_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("slot index set on a failed command");

  // A command is held until its result is produced, so the input drops after each transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transfer");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qpht_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 250;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned KeyPoolDepth  = 48;

  typedef struct packed {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
  } command_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
  } outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [CmdW-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  quadratic_probe_hash_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  logic [KeyW-1:0]     slot_key  [MaxSlots] = '{default: '0};
  bit                  slot_used [MaxSlots] = '{default: 1'b0};
  bit                  slot_tomb [MaxSlots] = '{default: 1'b0};
  int unsigned         entry_total  = 0;
  logic [CfgDataW-1:0] capacity_reg = CapacityReset;
  logic [CfgDataW-1:0] limit_reg    = LoadLimitReset;

  command_t        pending_commands[$];
  outcome_t        expected_outcomes[$];
  logic [KeyW-1:0] key_pool[$];

  int unsigned commands_queued = 0;
  int unsigned results_seen    = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_requests   = 0;
  int unsigned hold_served     = 0;
  int unsigned hold_left       = 0;
  bit          in_taken        = 1'b0;

  function automatic int unsigned probe_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > MaxSlots) return MaxSlots;
    return capacity_reg;
  endfunction

  function automatic int unsigned probe_index(input logic [KeyW-1:0] key,
                                              input int unsigned i, input int unsigned cap);
    return (32'(key) % cap + i * i) % cap;
  endfunction

  function automatic bit locate_key(input logic [KeyW-1:0] key, input int unsigned cap,
                                    output int unsigned where);
    int unsigned s;
    where = 0;
    for (int unsigned i = 0; i < cap; i++) begin
      s = probe_index(key, i, cap);
      if (!slot_used[s] && !slot_tomb[s]) return 1'b0;
      if (slot_used[s] && slot_key[s] == key) begin
        where = s;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic outcome_t apply_command(input command_t c);
    int unsigned cap;
    int unsigned where;
    int unsigned s;
    outcome_t    r;
    cap      = probe_capacity();
    r.status = ST_MISS;
    r.slot   = '0;
    case (c.cmd)
      CMD_INSERT: begin
        if (locate_key(c.key, cap, where)) begin
          r.status = ST_DUP;
        end else if (entry_total >= limit_reg) begin
          r.status = ST_LIMIT;
        end else begin
          r.status = ST_FULL;
          for (int unsigned i = 0; i < cap; i++) begin
            s = probe_index(c.key, i, cap);
            if (!slot_used[s]) begin
              slot_key[s]  = c.key;
              slot_used[s] = 1'b1;
              slot_tomb[s] = 1'b0;
              entry_total  = (entry_total + 1) & 32'h7F;
              r.status     = ST_OK;
              r.slot       = s[SlotW-1:0];
              break;
            end
          end
        end
      end
      CMD_SEARCH: begin
        if (locate_key(c.key, cap, where)) begin
          r.status = ST_OK;
          r.slot   = where[SlotW-1:0];
        end
      end
      CMD_REMOVE: begin
        if (locate_key(c.key, cap, where)) begin
          slot_used[where] = 1'b0;
          slot_tomb[where] = 1'b1;
          if (entry_total > 0) entry_total--;
          r.status = ST_OK;
          r.slot   = where[SlotW-1:0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Nearly half of the keys come back from a pool of recent inserts, so that duplicates, hits and
  // removals are common; small keys crowd the same home slots.
  function automatic command_t random_command(input int unsigned cap);
    command_t    c;
    int unsigned roll;
    int unsigned pick;
    roll  = $urandom_range(99);
    c.key = ($urandom_range(1) != 0) ? KeyW'($urandom()) : KeyW'($urandom_range(4 * cap + 3));
    c.cmd = CMD_INSERT;
    if (roll >= 35 && roll < 80 && key_pool.size() != 0) begin
      pick  = $urandom_range(key_pool.size() - 1);
      c.key = key_pool[pick];
      if (roll < 45) begin
        c.cmd = CMD_INSERT;
      end else if (roll < 65) begin
        c.cmd = CMD_SEARCH;
      end else begin
        c.cmd = CMD_REMOVE;
        key_pool.delete(pick);
      end
    end else if (roll >= 80 && roll < 92) begin
      c.cmd = ($urandom_range(1) != 0) ? CMD_SEARCH : CMD_REMOVE;
    end else if (roll >= 92) begin
      c.cmd = CMD_UNUSED;
    end else begin
      key_pool.push_back(c.key);
      if (key_pool.size() > KeyPoolDepth) key_pool.delete(0);
    end
    return c;
  endfunction

  task automatic queue_command(input cmd_e cmd, input logic [KeyW-1:0] key);
    pending_commands.push_back('{cmd: cmd, key: key});
    commands_queued++;
  endtask

  task automatic queue_random(input int unsigned count, input int unsigned cap);
    repeat (count) begin
      pending_commands.push_back(random_command(cap));
      commands_queued++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (results_seen < commands_queued);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    command_t cmd_out;
    if (!rst_ni || !s_axis_tvalid || in_taken) begin
      if (rst_ni && pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_out       = pending_commands.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'(cmd_out.key);
        s_axis_tuser  <= cmd_out.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_served   <= hold_requests;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          error_count++;
          $error("unexpected result transfer: status %0d, slot_index %0d",
                 m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_outcomes.pop_front();
          if (m_axis_tuser !== want.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          end
          if (m_axis_tdata !== OutDataW'(want.slot)) begin
            error_count++;
            $error("slot_index: expected %0d, got %0d", want.slot, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.push_back(apply_command('{cmd: cmd_e'(s_axis_tuser),
                                                    key: s_axis_tdata[KeyW-1:0]}));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegCapacity:  capacity_reg = cfg_data_i;
          RegLoadLimit: limit_reg    = cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(0, 0);
    queue_command(CMD_INSERT, 31'd0);
    queue_command(CMD_INSERT, 31'h7FFF_FFFF);
    queue_command(CMD_INSERT, 31'd7);
    queue_command(CMD_INSERT, 31'd14);
    queue_command(CMD_INSERT, 31'd0);
    queue_command(CMD_SEARCH, 31'd14);
    queue_command(CMD_SEARCH, 31'd21);
    queue_command(CMD_REMOVE, 31'd7);
    queue_command(CMD_SEARCH, 31'd14);
    queue_command(CMD_INSERT, 31'd21);
    queue_command(CMD_UNUSED, 31'd14);
    queue_command(CMD_SEARCH, 31'd14);
    queue_command(CMD_REMOVE, 31'd100);
    queue_command(CMD_INSERT, 31'd1);
    queue_command(CMD_INSERT, 31'd2);
    queue_command(CMD_INSERT, 31'd3);
    queue_command(CMD_SEARCH, 31'h7FFF_FFFF);
    queue_random(100, 7);
    wait_drained();

    set_idling(63, 0);
    write_reg(RegCapacity, 7'd4);
    write_reg(RegLoadLimit, 7'd127);
    queue_command(CMD_INSERT, 31'd8);
    queue_command(CMD_INSERT, 31'd12);
    queue_command(CMD_SEARCH, 31'd8);
    queue_command(CMD_REMOVE, 31'd0);
    queue_random(100, 4);
    wait_drained();

    set_idling(0, 63);
    write_reg(RegCapacity, 7'd0);
    queue_random(60, 1);
    wait_drained();

    set_idling(15, 15);
    write_reg(RegCapacity, 7'd127);
    write_reg(RegLoadLimit, 7'd40);
    queue_random(250, 64);
    wait_drained();

    set_idling(0, 0);
    write_reg(RegLoadLimit, 7'd0);
    write_reg(RegSpareA, 7'h7F);
    write_reg(RegSpareB, 7'h55);
    queue_random(50, 64);
    wait_drained();

    set_idling(63, 0);
    write_reg(RegCapacity, 7'd13);
    write_reg(RegLoadLimit, 7'd127);
    queue_random(200, 13);
    wait_drained();

    set_idling(0, 63);
    write_reg(RegCapacity, 7'd64);
    write_reg(RegLoadLimit, 7'd64);
    queue_random(300, 64);
    wait_drained();

    set_idling(15, 15);
    write_reg(RegCapacity, 7'd1);
    write_reg(RegLoadLimit, 7'd100);
    queue_random(60, 1);
    wait_drained();

    // The receiver holds off for a long stretch while commands keep coming, so the
    // block fills up and stalls its input.
    set_idling(0, 0);
    write_reg(RegCapacity, 7'd37);
    write_reg(RegLoadLimit, 7'd127);
    queue_random(300, 37);
    hold_requests++;
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[quadratic_probe_hash_table.f]
rtl/qpht_pkg.sv
rtl/quadratic_probe_hash_table.sv
rtl/qpht_checker.sv
sim/testbench.sv
